// ===== design/gfc_pkg.sv =====
// shared types and codes for the gif frame compositor
`default_nettype none
package gfc_pkg;

  localparam int CoordW = 16;
  localparam int RgbW   = 24;
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // command codes of the input beat
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PAL   = 3'd1;
  localparam logic [2:0] CMD_BEGIN = 3'd2;
  localparam logic [2:0] CMD_PIXEL = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // disposal methods with an action
  localparam logic [2:0] DISP_BACKGROUND = 3'd2;
  localparam logic [2:0] DISP_RESTORE    = 3'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_BACKGROUND = 2'd0;
  localparam logic [1:0] CFG_WIDTH      = 2'd1;
  localparam logic [1:0] CFG_HEIGHT     = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PAL   = 3'd1,
    OP_BEGIN = 3'd2,
    OP_PIXEL = 3'd3,
    OP_END   = 3'd4,
    OP_READ  = 3'd5,
    OP_NOP   = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [CoordW-1:0] rect_x;
    logic [CoordW-1:0] rect_y;
    logic [CoordW-1:0] rect_w;
    logic [CoordW-1:0] rect_h;
    logic [2:0]        disposal;
    logic              has_transparency;
    logic [7:0]        transparent_index;
    logic [CoordW-1:0] pixel_row;
    logic [CoordW-1:0] pixel_col;
    logic [7:0]        color_index;
    logic [RgbW-1:0]   palette_color;
  } cmd_t;

  typedef struct packed {
    op_e               op;
    logic              idx_ok;
    logic [CoordW-1:0] rect_x;
    logic [CoordW-1:0] rect_y;
    logic [CoordW-1:0] rect_w;
    logic [CoordW-1:0] rect_h;
    logic [2:0]        disposal;
    logic              has_transparency;
    logic [7:0]        transparent_index;
    logic [CoordW-1:0] pixel_row;
    logic [CoordW-1:0] pixel_col;
    logic [7:0]        color_index;
    logic [RgbW-1:0]   palette_color;
  } item_t;

  typedef struct packed {
    logic [RgbW-1:0] background;
    logic [6:0]      width;
    logic [6:0]      height;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/gfc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module gfc_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output logic      [Width-1:0]     rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/gfc_front.sv =====
// front end: decodes command beats and queues them for the back end
`default_nettype none
module gfc_front #(
  parameter int PaletteDepth = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gfc_pkg::cmd_t cmd_i,
  output logic               q_valid_o,
  output gfc_pkg::item_t     q_item_o,
  input  wire logic          q_pop_i
);
  import gfc_pkg::*;

  item_t            ent_q [QDepth];
  item_t            dec;
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;
  logic             push;

  always_comb begin
    case (cmd_i.command)
      CMD_CLEAR: dec.op = OP_CLEAR;
      CMD_PAL:   dec.op = OP_PAL;
      CMD_BEGIN: dec.op = OP_BEGIN;
      CMD_PIXEL: dec.op = OP_PIXEL;
      CMD_END:   dec.op = OP_END;
      CMD_READ:  dec.op = OP_READ;
      default:   dec.op = OP_NOP;
    endcase
    dec.idx_ok            = (32'(cmd_i.color_index) < PaletteDepth);
    dec.rect_x            = cmd_i.rect_x;
    dec.rect_y            = cmd_i.rect_y;
    dec.rect_w            = cmd_i.rect_w;
    dec.rect_h            = cmd_i.rect_h;
    dec.disposal          = cmd_i.disposal;
    dec.has_transparency  = cmd_i.has_transparency;
    dec.transparent_index = cmd_i.transparent_index;
    dec.pixel_row         = cmd_i.pixel_row;
    dec.pixel_col         = cmd_i.pixel_col;
    dec.color_index       = cmd_i.color_index;
    dec.palette_color     = cmd_i.palette_color;
  end

  assign in_ready_o = (cnt_q != QCntW'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (q_pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= dec;
    end
  end

  queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== design/gfc_back.sv =====
// back end: carries out queued commands on the canvas, snapshot and palette
`default_nettype none
module gfc_back #(
  parameter int MaxWidth     = 64,
  parameter int MaxHeight    = 64,
  parameter int PaletteDepth = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gfc_pkg::cfg_t   cfg_i,
  input  wire logic            q_valid_i,
  input  wire gfc_pkg::item_t  q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [23:0]          read_color_o,
  output logic                 saw_alpha_o
);
  import gfc_pkg::*;

  localparam int Cells = MaxWidth * MaxHeight;
  localparam int CAW   = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CIW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RIW   = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int EWW   = $clog2(MaxWidth + 1);
  localparam int EHW   = $clog2(MaxHeight + 1);
  localparam int PAW   = $clog2(PaletteDepth);
  localparam logic [CAW-1:0] LastCell = CAW'(Cells - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FILL    = 6'b000010,
    S_RESTORE = 6'b000100,
    S_SNAP    = 6'b001000,
    S_PIX     = 6'b010000,
    S_READ    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CoordW-1:0] cx_q, cy_q, cw_q, ch_q, cx_d, cy_d, cw_d, ch_d;
  logic [CoordW-1:0] px_q, py_q, pw_q, ph_q, px_d, py_d, pw_d, ph_d;
  logic [2:0]        cd_q, pd_q, cd_d, pd_d;
  logic              tv_q, tv_d, alpha_q, alpha_d, snap_q, snap_d;
  logic [7:0]        ti_q, ti_d;

  logic [RIW-1:0] fr_q, fr_d, fyl_q, fyl_d;
  logic [CIW-1:0] fc_q, fc_d, fx0_q, fx0_d, fxl_q, fxl_d;
  logic [CAW-1:0] cp_cnt_q, cp_cnt_d, cp_a_q, cp_a_d;
  logic           cp_stop_q, cp_stop_d, cp_v_q, cp_v_d;
  logic           hit_q, hit_d, idx_ok_q, idx_ok_d, rd_ok_q, rd_ok_d;

  logic            out_valid_q, out_valid_d;
  logic [RgbW-1:0] color_q, color_d;
  logic            sa_q, sa_d;
  logic            emit;
  logic [RgbW-1:0] emit_color;

  logic [EWW-1:0] ew;
  logic [EHW-1:0] eh;

  // canvas, snapshot and palette ports
  logic            cv_we, bk_we, pl_we;
  logic [CAW-1:0]  cv_wa, cv_ra, bk_wa;
  logic [RgbW-1:0] cv_wd, cv_rd, bk_wd, bk_rd, pl_rd;
  logic [PAW-1:0]  pl_wa, pl_ra;

  // fill bounds
  logic [CoordW:0] f_x, f_y, f_x1, f_y1, f_sx, f_sy;
  logic            f_any;
  logic [CoordW:0] pix_x, pix_y;
  logic            pix_in;

  item_t it;
  assign it = q_item_i;

  assign ew = (32'(cfg_i.width) < MaxWidth) ? EWW'(cfg_i.width) : EWW'(MaxWidth);
  assign eh = (32'(cfg_i.height) < MaxHeight) ? EHW'(cfg_i.height) : EHW'(MaxHeight);

  always_comb begin
    if (it.op == OP_CLEAR) begin
      f_x  = '0;
      f_y  = '0;
      f_sx = (CoordW+1)'(ew);
      f_sy = (CoordW+1)'(eh);
    end else begin
      f_x  = {1'b0, px_q};
      f_y  = {1'b0, py_q};
      f_sx = {1'b0, px_q} + {1'b0, pw_q};
      f_sy = {1'b0, py_q} + {1'b0, ph_q};
    end
    f_x1  = (f_sx < (CoordW+1)'(ew)) ? f_sx : (CoordW+1)'(ew);
    f_y1  = (f_sy < (CoordW+1)'(eh)) ? f_sy : (CoordW+1)'(eh);
    f_any = (f_x < f_x1) && (f_y < f_y1);
  end

  assign pix_x  = {1'b0, cx_q} + {1'b0, it.pixel_col};
  assign pix_y  = {1'b0, cy_q} + {1'b0, it.pixel_row};
  assign pix_in = (it.pixel_col < cw_q) && (it.pixel_row < ch_q) &&
                  (pix_x < (CoordW+1)'(ew)) && (pix_y < (CoordW+1)'(eh)) &&
                  !(tv_q && it.color_index == ti_q);

  always_comb begin
    state_d     = state_q;
    cx_d = cx_q; cy_d = cy_q; cw_d = cw_q; ch_d = ch_q;
    px_d = px_q; py_d = py_q; pw_d = pw_q; ph_d = ph_q;
    cd_d = cd_q; pd_d = pd_q; tv_d = tv_q; ti_d = ti_q;
    alpha_d     = alpha_q;
    snap_d      = snap_q;
    fr_d = fr_q; fc_d = fc_q; fx0_d = fx0_q; fxl_d = fxl_q; fyl_d = fyl_q;
    cp_cnt_d    = cp_cnt_q;
    cp_stop_d   = cp_stop_q;
    cp_v_d      = 1'b0;
    cp_a_d      = cp_a_q;
    hit_d       = hit_q;
    idx_ok_d    = idx_ok_q;
    rd_ok_d     = rd_ok_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    emit_color  = '0;
    cv_we       = 1'b0;
    cv_wa       = CAW'(fr_q) * CAW'(MaxWidth) + CAW'(fc_q);
    cv_wd       = cfg_i.background;
    cv_ra       = CAW'(it.pixel_row) * CAW'(MaxWidth) + CAW'(it.pixel_col);
    bk_we       = 1'b0;
    bk_wa       = cp_a_q;
    bk_wd       = cv_rd;
    pl_we       = 1'b0;
    pl_wa       = PAW'(it.color_index);
    pl_ra       = PAW'(it.color_index);

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && (!out_valid_q || out_ready_i)) begin
          q_pop_o = 1'b1;
          fx0_d   = CIW'(f_x);
          fc_d    = CIW'(f_x);
          fr_d    = RIW'(f_y);
          fxl_d   = CIW'(f_x1 - 1'b1);
          fyl_d   = RIW'(f_y1 - 1'b1);
          cp_cnt_d  = '0;
          cp_stop_d = 1'b0;
          case (it.op)
            OP_CLEAR: begin
              cx_d = '0; cy_d = '0; cw_d = '0; ch_d = '0; cd_d = '0;
              px_d = '0; py_d = '0; pw_d = '0; ph_d = '0; pd_d = '0;
              alpha_d = 1'b0;
              snap_d  = 1'b0;
              if (f_any) begin
                state_d = S_FILL;
              end else begin
                emit = 1'b1;
              end
            end
            OP_PAL: begin
              pl_we = it.idx_ok;
              emit  = 1'b1;
            end
            OP_BEGIN: begin
              cx_d = it.rect_x; cy_d = it.rect_y;
              cw_d = it.rect_w; ch_d = it.rect_h;
              cd_d = it.disposal;
              tv_d = it.has_transparency;
              ti_d = it.transparent_index;
              alpha_d = alpha_q | it.has_transparency;
              snap_d  = (it.disposal == DISP_RESTORE);
              if (pd_q == DISP_BACKGROUND && f_any) begin
                state_d = S_FILL;
              end else if (pd_q == DISP_RESTORE) begin
                state_d = S_RESTORE;
              end else if (it.disposal == DISP_RESTORE) begin
                state_d = S_SNAP;
              end else begin
                emit = 1'b1;
              end
            end
            OP_PIXEL: begin
              hit_d    = pix_in;
              idx_ok_d = it.idx_ok;
              cv_ra    = CAW'(pix_y) * CAW'(MaxWidth) + CAW'(pix_x);
              cp_a_d   = CAW'(pix_y) * CAW'(MaxWidth) + CAW'(pix_x);
              state_d  = S_PIX;
            end
            OP_END: begin
              px_d = cx_q; py_d = cy_q; pw_d = cw_q; ph_d = ch_q; pd_d = cd_q;
              emit = 1'b1;
            end
            OP_READ: begin
              rd_ok_d = (it.pixel_row < CoordW'(eh)) && (it.pixel_col < CoordW'(ew));
              state_d = S_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        cv_we = 1'b1;
        if (fc_q == fxl_q) begin
          fc_d = fx0_q;
          if (fr_q == fyl_q) begin
            if (snap_q) begin
              state_d = S_SNAP;
            end else begin
              state_d = S_IDLE;
              emit    = 1'b1;
            end
          end else begin
            fr_d = fr_q + 1'b1;
          end
        end else begin
          fc_d = fc_q + 1'b1;
        end
      end
      S_RESTORE, S_SNAP: begin
        // one cell read per cycle, written the cycle after
        cv_ra = cp_cnt_q;
        if (!cp_stop_q) begin
          cp_v_d = 1'b1;
          cp_a_d = cp_cnt_q;
          if (cp_cnt_q == LastCell) begin
            cp_stop_d = 1'b1;
          end else begin
            cp_cnt_d = cp_cnt_q + 1'b1;
          end
        end
        if (state_q == S_RESTORE) begin
          cv_we = cp_v_q;
          cv_wa = cp_a_q;
          cv_wd = bk_rd;
        end else begin
          bk_we = cp_v_q;
        end
        if (cp_v_q && cp_a_q == LastCell) begin
          cp_v_d    = 1'b0;
          cp_cnt_d  = '0;
          cp_stop_d = 1'b0;
          if (state_q == S_RESTORE && snap_q) begin
            state_d = S_SNAP;
          end else begin
            state_d = S_IDLE;
            emit    = 1'b1;
          end
        end
      end
      S_PIX: begin
        cv_we   = hit_q;
        cv_wa   = cp_a_q;
        cv_wd   = idx_ok_q ? pl_rd : '0;
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      S_READ: begin
        emit       = 1'b1;
        emit_color = rd_ok_q ? cv_rd : '0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    color_d     = color_q;
    sa_d        = sa_q;
    if (emit) begin
      out_valid_d = 1'b1;
      color_d     = emit_color;
      sa_d        = alpha_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cx_q <= '0; cy_q <= '0; cw_q <= '0; ch_q <= '0;
      px_q <= '0; py_q <= '0; pw_q <= '0; ph_q <= '0;
      cd_q <= '0; pd_q <= '0; tv_q <= 1'b0; ti_q <= '0;
      alpha_q     <= 1'b0;
      snap_q      <= 1'b0;
      cp_stop_q   <= 1'b0;
      cp_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cx_q <= cx_d; cy_q <= cy_d; cw_q <= cw_d; ch_q <= ch_d;
      px_q <= px_d; py_q <= py_d; pw_q <= pw_d; ph_q <= ph_d;
      cd_q <= cd_d; pd_q <= pd_d; tv_q <= tv_d; ti_q <= ti_d;
      alpha_q     <= alpha_d;
      snap_q      <= snap_d;
      cp_stop_q   <= cp_stop_d;
      cp_v_q      <= cp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q     <= fr_d;
    fc_q     <= fc_d;
    fx0_q    <= fx0_d;
    fxl_q    <= fxl_d;
    fyl_q    <= fyl_d;
    cp_cnt_q <= cp_cnt_d;
    cp_a_q   <= cp_a_d;
    hit_q    <= hit_d;
    idx_ok_q <= idx_ok_d;
    rd_ok_q  <= rd_ok_d;
    color_q  <= color_d;
    sa_q     <= sa_d;
  end

  gfc_ram #(.Width(RgbW), .Depth(Cells)) u_canvas (
    .clk_i  (clk_i),
    .we_i   (cv_we),
    .waddr_i(cv_wa),
    .wdata_i(cv_wd),
    .raddr_i(cv_ra),
    .rdata_o(cv_rd)
  );

  gfc_ram #(.Width(RgbW), .Depth(Cells)) u_backup (
    .clk_i  (clk_i),
    .we_i   (bk_we),
    .waddr_i(bk_wa),
    .wdata_i(bk_wd),
    .raddr_i(cp_cnt_q),
    .rdata_o(bk_rd)
  );

  gfc_ram #(.Width(RgbW), .Depth(PaletteDepth)) u_palette (
    .clk_i  (clk_i),
    .we_i   (pl_we),
    .waddr_i(pl_wa),
    .wdata_i(it.palette_color),
    .raddr_i(pl_ra),
    .rdata_o(pl_rd)
  );

  assign out_valid_o  = out_valid_q;
  assign read_color_o = color_q;
  assign saw_alpha_o  = sa_q;

  state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE && (!out_valid_q || out_ready_i))
    else $error("queue popped while busy or result pending");

  fill_in_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> 32'(fr_q) < MaxHeight && 32'(fc_q) < MaxWidth)
    else $error("fill outside built canvas");
endmodule
`default_nettype wire

// ===== design/gif_frame_compositor.sv =====
// top level: gif frame compositor with decoupled command queue and executor
// palette write, end frame, unused commands finish in idle; pixel, read use S_PIX, S_READ
// clear and disposal 2 fills write each covered pixel; disposal 3 restore and snapshot
// copy all MAX_WIDTH*MAX_HEIGHT cells; the queue takes commands while the executor is
// busy until full, and the executor starts one only when idle with no result pending
// reset clears control, frame records, background, sets size 64; rams keep garbage
`default_nettype none
module gif_frame_compositor #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [15:0] rect_x_i,
  input  wire logic [15:0] rect_y_i,
  input  wire logic [15:0] rect_w_i,
  input  wire logic [15:0] rect_h_i,
  input  wire logic [2:0]  disposal_i,
  input  wire logic        has_transparency_i,
  input  wire logic [7:0]  transparent_index_i,
  input  wire logic [15:0] pixel_row_i,
  input  wire logic [15:0] pixel_col_i,
  input  wire logic [7:0]  color_index_i,
  input  wire logic [23:0] palette_color_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      read_color_o,
  output logic             saw_alpha_o
);
  import gfc_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  item_t q_item;
  logic  q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.background <= '0;
      cfg_q.width      <= 7'd64;
      cfg_q.height     <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BACKGROUND: cfg_q.background <= cfg_data_i;
        CFG_WIDTH:      cfg_q.width      <= cfg_data_i[6:0];
        CFG_HEIGHT:     cfg_q.height     <= cfg_data_i[6:0];
        default:        ;
      endcase
    end
  end

  assign cmd.command           = command_i;
  assign cmd.rect_x            = rect_x_i;
  assign cmd.rect_y            = rect_y_i;
  assign cmd.rect_w            = rect_w_i;
  assign cmd.rect_h            = rect_h_i;
  assign cmd.disposal          = disposal_i;
  assign cmd.has_transparency  = has_transparency_i;
  assign cmd.transparent_index = transparent_index_i;
  assign cmd.pixel_row         = pixel_row_i;
  assign cmd.pixel_col         = pixel_col_i;
  assign cmd.color_index       = color_index_i;
  assign cmd.palette_color     = palette_color_i;

  gfc_front #(.PaletteDepth(PALETTE_DEPTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i     (cmd),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  gfc_back #(
    .MaxWidth    (MAX_WIDTH),
    .MaxHeight   (MAX_HEIGHT),
    .PaletteDepth(PALETTE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_color_o(read_color_o),
    .saw_alpha_o (saw_alpha_o)
  );
endmodule
`default_nettype wire
